[rtl/core/bsre_pkg.sv]
// ----------------------------------------------------------------------------
// Bitmap scan and range engine package
// Opcodes, register map, shared word-unit types and the leading-zero helper.
// ----------------------------------------------------------------------------
package bsre_pkg;

   localparam logic [1:0] OP_FIND_SET  = 2'd0;
   localparam logic [1:0] OP_FIND_ZERO = 2'd1;
   localparam logic [1:0] OP_CLR_RANGE = 2'd2;
   localparam logic [1:0] OP_SET_RANGE = 2'd3;

   localparam int unsigned WIDX_W = 11;

   localparam logic [31:0]       ALL_ONES    = 32'hFFFF_FFFF;
   localparam logic [4:0]        LAST_OFFSET = 5'h1F;
   localparam logic              REG_WORDS_IN_USE = 1'b0;
   localparam logic [WIDX_W-1:0] WORDS_RESET = 11'd1024;

   typedef struct packed {
      logic [1:0] op;
      logic [4:0] lo;
      logic [4:0] hi;
   } bsre_wcmd_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] find_word;
      logic [31:0] wr_data;
      logic [4:0]  lzc;
   } bsre_wres_type;

   typedef struct packed {
      logic        found;
      logic [14:0] position;
      logic [15:0] bits_changed;
   } bsre_result_type;

   function automatic logic [4:0] lead_zeros(input logic [31:0] v);
      logic [31:0] w;
      logic [4:0]  n;
      w = v;
      n = 5'd0;
      if (w[31:16] == 16'd0) begin
         n[4] = 1'b1;
         w = {w[15:0], 16'd0};
      end
      if (w[31:24] == 8'd0) begin
         n[3] = 1'b1;
         w = {w[23:0], 8'd0};
      end
      if (w[31:28] == 4'd0) begin
         n[2] = 1'b1;
         w = {w[27:0], 4'd0};
      end
      if (w[31:30] == 2'd0) begin
         n[1] = 1'b1;
         w = {w[29:0], 2'd0};
      end
      if (w[31] == 1'b0) begin
         n[0] = 1'b1;
      end
      return n;
   endfunction

endpackage

[rtl/core/bsre_bitmap_ram.sv]
// ----------------------------------------------------------------------------
// Bitmap word store
// One write port and one registered read port over the bitmap words.
// ----------------------------------------------------------------------------
module bsre_bitmap_ram #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bsre_word_unit.sv]
// ----------------------------------------------------------------------------
// Bitmap word unit
// Builds the span mask of one word, tests it for a find and merges it for a
// clear or set, and counts leading zeros of a captured hit word.
// ----------------------------------------------------------------------------
module bsre_word_unit
   import bsre_pkg::*;
(
   input  bsre_wcmd_type cmd,
   input  logic [31:0]   rd_data,
   input  logic [31:0]   hit_word,
   output bsre_wres_type res
);

   logic [31:0] mask;
   logic [31:0] probe;

   always_comb begin
      mask  = (ALL_ONES >> cmd.lo) & (ALL_ONES << (LAST_OFFSET - cmd.hi));
      probe = (rd_data ^ {32{cmd.op == OP_FIND_ZERO}}) & mask;
      res.find_word = probe;
      res.hit       = |probe;
      if (cmd.op == OP_SET_RANGE) begin
         res.wr_data = rd_data | mask;
      end else begin
         res.wr_data = rd_data & ~mask;
      end
      res.lzc = lead_zeros(hit_word);
   end

endmodule

[rtl/core/bsre_ctrl.sv]
// ----------------------------------------------------------------------------
// Bitmap engine sequencer
// Clears the store after reset, plans each request and walks the words of
// its span one per cycle through the shared word unit.
// ----------------------------------------------------------------------------
module bsre_ctrl
   import bsre_pkg::*;
#(
   parameter int unsigned MAX_WORDS = 1024,
   parameter int unsigned AW        = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_opcode,
   input  logic [14:0]       req_start_bit,
   input  logic [15:0]       req_bit_count,
   output logic              req_stall,
   input  logic [WIDX_W-1:0] words_in_use,
   input  logic              out_free,
   output logic              res_valid,
   output bsre_result_type   res,
   output logic              ram_wr_en,
   output logic [AW-1:0]     ram_wr_addr,
   output logic [31:0]       ram_wr_data,
   output logic [AW-1:0]     ram_rd_addr,
   input  logic [31:0]       ram_rd_data
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_PREP   = 3'd2;
   localparam logic [2:0] S_PLAN   = 3'd3;
   localparam logic [2:0] S_RUN    = 3'd4;
   localparam logic [2:0] S_LZC    = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   localparam int unsigned       CLAMP   = (MAX_WORDS > 2047) ? 2047 : MAX_WORDS;
   localparam logic [WIDX_W-1:0] CLAMP_W = WIDX_W'(CLAMP);
   localparam logic [AW-1:0]     LAST_ADDR = AW'(MAX_WORDS - 1);

   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [1:0]        op_ff, op_in;
   logic [14:0]       start_ff, start_in;
   logic [15:0]       count_ff, count_in;
   logic              oor_ff, oor_in;
   logic [15:0]       avail_ff, avail_in;
   logic [15:0]       n_ff, n_in;
   logic [WIDX_W-1:0] last_ff, last_in;
   logic [4:0]        last_off_ff, last_off_in;
   logic [WIDX_W-1:0] rd_word_ff, rd_word_in;
   logic              dv_ff, dv_in;
   logic [WIDX_W-1:0] dw_ff, dw_in;
   logic [31:0]       hit_word_ff, hit_word_in;
   logic [WIDX_W-1:0] hit_idx_ff, hit_idx_in;
   bsre_result_type   res_ff, res_in;

   logic [WIDX_W-1:0] eff_words;
   logic [15:0]       limit_bits;
   logic [15:0]       last_bit;
   logic [WIDX_W-1:0] first_word;
   logic              is_range;
   logic              is_first;
   logic              is_last;
   logic              accept;
   logic              issue;
   bsre_wcmd_type     wcmd;
   bsre_wres_type     wres;

   bsre_word_unit u_word_unit (
      .cmd      (wcmd),
      .rd_data  (ram_rd_data),
      .hit_word (hit_word_ff),
      .res      (wres)
   );

   always_comb begin
      eff_words  = (words_in_use > CLAMP_W) ? CLAMP_W : words_in_use;
      limit_bits = {eff_words, 5'd0};
      last_bit   = {1'b0, start_ff} + n_ff - 16'd1;
      first_word = {1'b0, start_ff[14:5]};
      is_range   = (op_ff == OP_CLR_RANGE) || (op_ff == OP_SET_RANGE);
      is_first   = (dw_ff == first_word);
      is_last    = (dw_ff == last_ff);
      accept     = req_valid && !req_stall;
      issue      = (state_ff == S_RUN) && (rd_word_ff <= last_ff);
      wcmd.op    = op_ff;
      wcmd.lo    = is_first ? start_ff[4:0] : 5'd0;
      wcmd.hi    = (is_range && is_last) ? last_off_ff : LAST_OFFSET;
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      op_in       = op_ff;
      start_in    = start_ff;
      count_in    = count_ff;
      oor_in      = oor_ff;
      avail_in    = avail_ff;
      n_in        = n_ff;
      last_in     = last_ff;
      last_off_in = last_off_ff;
      rd_word_in  = rd_word_ff;
      dv_in       = issue;
      dw_in       = rd_word_ff;
      hit_word_in = hit_word_ff;
      hit_idx_in  = hit_idx_ff;
      res_in      = res_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = AW'(dw_ff);
      ram_wr_data = wres.wr_data;
      if (issue) begin
         rd_word_in = rd_word_ff + 11'd1;
      end
      case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = 32'd0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               start_in = req_start_bit;
               count_in = req_bit_count;
               oor_in   = ({1'b0, req_start_bit} >= limit_bits);
               avail_in = limit_bits - {1'b0, req_start_bit};
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            n_in     = (count_ff < avail_ff) ? count_ff : avail_ff;
            state_in = S_PLAN;
         end
         S_PLAN: begin
            res_in     = '0;
            rd_word_in = first_word;
            if (oor_ff || (is_range && (n_ff == 16'd0))) begin
               state_in = S_FINISH;
            end else begin
               last_in     = is_range ? last_bit[15:5] : (eff_words - 11'd1);
               last_off_in = last_bit[4:0];
               state_in    = S_RUN;
            end
         end
         S_RUN: begin
            if (dv_ff) begin
               if (is_range) begin
                  ram_wr_en = 1'b1;
                  if (is_last) begin
                     res_in.bits_changed = n_ff;
                     state_in            = S_FINISH;
                  end
               end else if (wres.hit) begin
                  hit_word_in = wres.find_word;
                  hit_idx_in  = dw_ff;
                  state_in    = S_LZC;
               end else if (is_last) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_LZC: begin
            res_in.found    = 1'b1;
            res_in.position = {hit_idx_ff[9:0], wres.lzc};
            state_in        = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         dv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         dv_ff    <= dv_in;
      end
      op_ff       <= op_in;
      start_ff    <= start_in;
      count_ff    <= count_in;
      oor_ff      <= oor_in;
      avail_ff    <= avail_in;
      n_ff        <= n_in;
      last_ff     <= last_in;
      last_off_ff <= last_off_in;
      rd_word_ff  <= rd_word_in;
      dw_ff       <= dw_in;
      hit_word_ff <= hit_word_in;
      hit_idx_ff  <= hit_idx_in;
      res_ff      <= res_in;
   end

   assign ram_rd_addr = AW'(rd_word_ff);
   assign res_valid   = (state_ff == S_FINISH);
   assign res         = res_ff;

   a_write_only_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && ram_wr_en) |-> is_range)
      else $error("store written during a find");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> ({1'b0, rd_word_ff} <= ({1'b0, last_ff} + 12'd1)))
      else $error("read pointer ran past the span");

   a_data_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && dv_ff) |-> (dw_ff <= last_ff && dw_ff >= first_word))
      else $error("word in flight lies outside the span");

   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |->
         ((res_ff.bits_changed == 16'd0 || is_range) && (!res_ff.found || !is_range)))
      else $error("result fields do not match the request kind");

endmodule

[rtl/core/bitmap_scan_and_range_engine.sv]
// ----------------------------------------------------------------------------
// Bitmap scan and range engine
// Finds the first set or zero bit from a start position, or clears or sets a
// run of bits, over a bitmap of 32-bit words counted from each word's MSB.
//
//   Channel   Direction  Handshake             Contents
//   req_*     in         req_valid/req_stall   opcode, start_bit, bit_count
//   rsp_*     out        rsp_valid/rsp_stall   found, position, bits_changed
//   csr_*     in/out     APB-style, pready=1   words_in_use at offset 0
//
// A request visits one bitmap word per cycle through the single read port of
// the store; a find that hits then passes through the leading-zero count, and
// a request whose start lies outside the region, or a range that is empty,
// visits no word.
// After reset the store is cleared word by word with req_stall high.
// Requests are taken one at a time; req_stall stays high until the result
// has been moved into the output register, which holds it under rsp_stall.
// ----------------------------------------------------------------------------
module bitmap_scan_and_range_engine
   import bsre_pkg::*;
#(
   parameter int unsigned MAX_WORDS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_opcode,
   input  logic [14:0] req_start_bit,
   input  logic [15:0] req_bit_count,
   output logic        req_stall,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic [14:0] rsp_position,
   output logic [15:0] rsp_bits_changed,
   input  logic        rsp_stall,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   logic [WIDX_W-1:0] words_ff, words_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bsre_result_type   rsp_ff, rsp_in;
   logic              out_free;
   logic              res_valid;
   bsre_result_type   res;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [31:0]       ram_wr_data;
   logic [AW-1:0]     ram_rd_addr;
   logic [31:0]       ram_rd_data;

   bsre_bitmap_ram #(
      .DEPTH (MAX_WORDS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bsre_ctrl #(
      .MAX_WORDS (MAX_WORDS),
      .AW        (AW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_opcode    (req_opcode),
      .req_start_bit (req_start_bit),
      .req_bit_count (req_bit_count),
      .req_stall     (req_stall),
      .words_in_use  (words_ff),
      .out_free      (out_free),
      .res_valid     (res_valid),
      .res           (res),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
      words_in = words_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          (csr_paddr[2] == REG_WORDS_IN_USE)) begin
         words_in = csr_pwdata[WIDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         words_ff     <= WORDS_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         words_ff     <= words_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_ff.found;
   assign rsp_position     = rsp_ff.position;
   assign rsp_bits_changed = rsp_ff.bits_changed;
   assign csr_pready       = 1'b1;
   assign csr_prdata       = (csr_paddr[2] == REG_WORDS_IN_USE) ?
                             {21'd0, words_ff} : 32'd0;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_ff == $past(rsp_ff)))
      else $error("held result was overwritten");

   a_no_request_while_busy: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> req_stall)
      else $error("request channel open while a result is pending");

   a_result_from_engine: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(res_valid))
      else $error("result appeared without a finished request");

endmodule
